[rtl/bsps_pkg.sv]
package bsps_pkg;

   // Fixed field widths of the channels
   localparam int DATA_W      = 64;
   localparam int LITERAL_W   = 32;
   localparam int LIT_IDX_W   = $clog2(LITERAL_W);
   localparam int KIND_W      = 3;
   localparam int CODE_BITS_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Parameter defaults
   localparam int DEF_LANE_COUNT    = 64;
   localparam int DEF_MAX_CODE_BITS = 32;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LITERAL   = 2'd0,
      CSR_KIND      = 2'd1,
      CSR_CODE_BITS = 2'd2
   } csr_index_type;

   // Comparison kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_EQ = 3'd0,
      KIND_NE = 3'd1,
      KIND_LT = 3'd2,
      KIND_LE = 3'd3,
      KIND_GT = 3'd4,
      KIND_GE = 3'd5
   } compare_kind_type;

   // Configuration seen by the scan datapath
   typedef struct packed {
      logic [LITERAL_W-1:0]   literal_value;
      logic [KIND_W-1:0]      compare_kind;
      logic [CODE_BITS_W-1:0] code_bits;
   } csr_type;

endpackage

[rtl/bit_sliced_predicate_scan.sv]
// Bit-sliced predicate scan over one segment of LANE_COUNT codes.
//
// Channels: req_ carries one slice word per item, most significant code
// bit first; req_filter_word is sampled only on the first slice of a
// segment. rsp_ returns one match word per segment, after its last slice.
// csr_ writes literal_value, compare_kind and code_bits by index; it is
// always ready. The user must write it only while idle; it is unchecked.
//
// Latency: the match word is valid the cycle after the last slice is
// taken. Throughput: one slice per cycle unless rsp_ stalls, set by the
// single mask-update stage between the mask and output registers.
//
// Reset clears the slice counter and the output valid flag, and restores
// the configuration to literal 0, equal compare, 1-bit codes.
//
// When the receiver stalls, the match word is held and req_ready stays
// low until it is taken, whether or not the next slice ends a segment:
// req_ready = !rsp_valid || rsp_ready.
module bit_sliced_predicate_scan
   import bsps_pkg::*;
#(
   parameter int LANE_COUNT    = DEF_LANE_COUNT,
   parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [DATA_W-1:0]      req_slice_word,
   input  logic [DATA_W-1:0]      req_filter_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DATA_W-1:0]      rsp_match_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_type               csr;
   logic                  accept, done;
   logic [LANE_COUNT-1:0] result;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_match_word_ff;

   bsps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_out   (csr)
   );

   bsps_mask_unit #(
      .LANE_COUNT    (LANE_COUNT),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_mask (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .slice  (req_slice_word[LANE_COUNT-1:0]),
      .filter (req_filter_word[LANE_COUNT-1:0]),
      .csr    (csr),
      .done   (done),
      .result (result)
   );

   // Output register frees up the same cycle it is drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept && done)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && done) begin
         rsp_match_word_ff <= DATA_W'(result);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_match_word = rsp_match_word_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("output valid after reset");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !accept)
      else $error("item taken while result stalled");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (accept && done) |=> rsp_valid_ff)
      else $error("segment end gave no result");

endmodule

[rtl/bsps_csr.sv]
module bsps_csr
   import bsps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output csr_type                csr_out
);

   csr_type regs_ff;
   csr_type regs_in;

   assign csr_ready = 1'b1;
   assign csr_out   = regs_ff;

   // Register decode; unknown indexes are dropped
   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LITERAL:   regs_in.literal_value = csr_wdata[LITERAL_W-1:0];
            CSR_KIND:      regs_in.compare_kind  = csr_wdata[KIND_W-1:0];
            CSR_CODE_BITS: regs_in.code_bits     = csr_wdata[CODE_BITS_W-1:0];
            default:       regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.literal_value <= '0;
         regs_ff.compare_kind  <= KIND_EQ;
         regs_ff.code_bits     <= CODE_BITS_W'(1);
      end else begin
         regs_ff <= regs_in;
      end
   end

   a_reset_len: assert property (@(posedge clock)
      reset |=> (regs_ff.code_bits == CODE_BITS_W'(1)))
      else $error("code length not restored by reset");

   a_kind_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> $stable(regs_ff))
      else $error("configuration changed without a write");

   a_ready: assert property (@(posedge clock) csr_ready)
      else $error("configuration port not ready");

endmodule

[rtl/bsps_mask_unit.sv]
module bsps_mask_unit
   import bsps_pkg::*;
#(
   parameter int LANE_COUNT    = DEF_LANE_COUNT,
   parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [LANE_COUNT-1:0] slice,
   input  logic [LANE_COUNT-1:0] filter,
   input  csr_type               csr,
   output logic                  done,
   output logic [LANE_COUNT-1:0] result
);

   localparam int SLICE_W = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;

   logic [LANE_COUNT-1:0]  equal_ff, equal_in, less_ff, less_in;
   logic [LANE_COUNT-1:0]  greater_ff, greater_in, held_ff, held_in;
   logic [SLICE_W-1:0]     slice_index_ff, slice_index_in;

   logic                   first;
   logic [LANE_COUNT-1:0]  eq_cur, lt_cur, gt_cur, lit_all;
   logic [CODE_BITS_W-1:0] len_eff, idx_ext, idx_next, bit_pos;
   logic                   lit_bit;

   // Effective code length: zero counts as one, saturate at the maximum
   always_comb begin
      if (csr.code_bits == '0)
         len_eff = CODE_BITS_W'(1);
      else if (csr.code_bits > CODE_BITS_W'(MAX_CODE_BITS))
         len_eff = CODE_BITS_W'(MAX_CODE_BITS);
      else
         len_eff = csr.code_bits;
   end

   // First slice of a segment seeds the masks from the filter
   assign first   = (slice_index_ff == '0);
   assign eq_cur  = first ? filter : equal_ff;
   assign lt_cur  = first ? '0 : less_ff;
   assign gt_cur  = first ? '0 : greater_ff;
   assign held_in = first ? filter : held_ff;

   // Literal bit for this slice, MSB first
   assign idx_ext  = CODE_BITS_W'(slice_index_ff);
   assign bit_pos  = len_eff - CODE_BITS_W'(1) - idx_ext;
   assign lit_bit  = (idx_ext < len_eff) && csr.literal_value[bit_pos[LIT_IDX_W-1:0]];
   assign lit_all  = {LANE_COUNT{lit_bit}};

   // Mask update
   assign less_in    = lt_cur | (eq_cur & ~slice & lit_all);
   assign greater_in = gt_cur | (eq_cur & slice & ~lit_all);
   assign equal_in   = eq_cur & ~(slice ^ lit_all);

   // Segment end
   assign idx_next       = idx_ext + CODE_BITS_W'(1);
   assign done           = (idx_next >= len_eff);
   assign slice_index_in = done ? '0 : idx_next[SLICE_W-1:0];

   // Comparison select, gated by the held filter
   always_comb begin
      unique case (csr.compare_kind)
         KIND_EQ: result = equal_in;
         KIND_NE: result = ~equal_in;
         KIND_LT: result = less_in;
         KIND_LE: result = less_in | equal_in;
         KIND_GT: result = greater_in;
         KIND_GE: result = greater_in | equal_in;
         default: result = '0;
      endcase
      result = result & held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_index_ff <= '0;
      end else if (accept) begin
         slice_index_ff <= slice_index_in;
      end
   end

   // Mask payload; valid once the first slice is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         equal_ff   <= equal_in;
         less_ff    <= less_in;
         greater_ff <= greater_in;
         held_ff    <= held_in;
      end
   end

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      CODE_BITS_W'(slice_index_ff) < CODE_BITS_W'(MAX_CODE_BITS))
      else $error("slice index past maximum code length");

   a_lt_gt_disjoint: assert property (@(posedge clock) disable iff (reset)
      accept |-> ((less_in & greater_in) == '0))
      else $error("lane both less and greater");

   a_eq_disjoint: assert property (@(posedge clock) disable iff (reset)
      accept |-> ((equal_in & (less_in | greater_in)) == '0))
      else $error("equal lane also ordered");

   a_index_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && done) |=> (slice_index_ff == '0))
      else $error("slice index not cleared at segment end");

endmodule

[bench/bit_sliced_predicate_scan_tb.sv]
module bit_sliced_predicate_scan_tb;
   import bsps_pkg::*;

   localparam int LIMIT_CYCLES = 100000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_COUNT  = 14;
   localparam int PHASE_ITEMS  = 60;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;
   localparam logic [KIND_W-1:0] KIND_LIST [8] = '{KIND_EQ, KIND_NE, KIND_LT, KIND_LE,
      KIND_GT, KIND_GE, KIND_UNUSED_6, KIND_UNUSED_7};

   localparam logic [DATA_W-1:0] ALL_LANES = {DATA_W{1'b1}} >> (DATA_W - DEF_LANE_COUNT);
   // lane i holds code i mod 4: high bit and low bit slices
   localparam logic [DATA_W-1:0] MOD4_HIGH = {(DATA_W/4){4'b1100}};
   localparam logic [DATA_W-1:0] MOD4_LOW  = {(DATA_W/4){4'b1010}};

   typedef struct packed {
      logic [DATA_W-1:0] slice_word;
      logic [DATA_W-1:0] filter_word;
   } slice_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [DATA_W-1:0] req_slice_word = '0;
   logic [DATA_W-1:0] req_filter_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DATA_W-1:0] rsp_match_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   slice_item_type slice_items[$];
   logic [DATA_W-1:0] match_expected[$];
   int unsigned items_left = 0;
   int unsigned cycle_count = 0;
   bit failed = 1'b0;
   bit steady = 1'b0;

   // shadow of the configuration registers
   logic [LITERAL_W-1:0] lit_code = '0;
   logic [KIND_W-1:0] kind_sel = KIND_EQ;
   logic [CODE_BITS_W-1:0] code_len_reg = 6'd1;

   // scan state of the segment in flight
   logic [DATA_W-1:0] eq_lanes = '0;
   logic [DATA_W-1:0] lt_lanes = '0;
   logic [DATA_W-1:0] gt_lanes = '0;
   logic [DATA_W-1:0] cand_lanes = '0;
   logic [CODE_BITS_W-1:0] slices_seen = '0;

   bit_sliced_predicate_scan dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_slice_word(req_slice_word),
      .req_filter_word(req_filter_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_match_word(rsp_match_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // slices per segment: zero means one, long codes clip at the maximum
   function automatic int unsigned seg_slices();
      if (code_len_reg == 0) return 1;
      if (code_len_reg > DEF_MAX_CODE_BITS) return DEF_MAX_CODE_BITS;
      return 32'(code_len_reg);
   endfunction

   // Fold one slice into the masks; returns 1 when the segment completes
   function automatic bit scan_slice(input logic [DATA_W-1:0] slice_in,
                                     input logic [DATA_W-1:0] filter_in,
                                     output logic [DATA_W-1:0] match);
      int unsigned len;
      logic [DATA_W-1:0] slice;
      logic [DATA_W-1:0] lit_lanes;
      len = seg_slices();
      slice = slice_in & ALL_LANES;
      lit_lanes = '0;
      match = '0;
      if (slices_seen == 0) begin
         cand_lanes = filter_in & ALL_LANES;
         eq_lanes = cand_lanes;
         lt_lanes = '0;
         gt_lanes = '0;
      end
      // past the new length the literal bit reads as zero
      if (slices_seen < len) begin
         if (lit_code[len - 1 - slices_seen]) lit_lanes = ALL_LANES;
      end
      lt_lanes |= eq_lanes & ~slice & lit_lanes;
      gt_lanes |= eq_lanes & slice & ~lit_lanes;
      eq_lanes &= ~(slice ^ lit_lanes);
      slices_seen = slices_seen + 1'b1;
      if (slices_seen < len) return 1'b0;
      slices_seen = '0;
      case (kind_sel)
         KIND_EQ: match = eq_lanes;
         KIND_NE: match = ~eq_lanes;
         KIND_LT: match = lt_lanes;
         KIND_LE: match = lt_lanes | eq_lanes;
         KIND_GT: match = gt_lanes;
         KIND_GE: match = gt_lanes | eq_lanes;
         default: match = '0;
      endcase
      match &= cand_lanes & ALL_LANES;
      return 1'b1;
   endfunction

   // Driver: present queued items, predict on acceptance
   always @(posedge clock) begin : drive_items
      logic [DATA_W-1:0] match;
      slice_item_type next_item;
      bit show;
      bit done;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         show = req_valid;
         if (req_valid && req_ready) begin
            done = scan_slice(req_slice_word, req_filter_word, match);
            if (done) match_expected.push_back(match);
            items_left--;
            show = 1'b0;
         end
         if (!show && slice_items.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
            next_item = slice_items.pop_front();
            req_slice_word <= next_item.slice_word;
            req_filter_word <= next_item.filter_word;
            show = 1'b1;
         end
         req_valid <= show;
      end
   end

   // Monitor: compare each match word with the oldest expectation
   always @(posedge clock) begin : check_matches
      logic [DATA_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (match_expected.size() == 0) begin
               $error("match_word: none expected, got %h", rsp_match_word);
               failed = 1'b1;
            end else begin
               want = match_expected.pop_front();
               if (want !== rsp_match_word) begin
                  $error("match_word: expected %h, got %h", want, rsp_match_word);
                  failed = 1'b1;
               end
            end
         end
         rsp_ready <= steady || $urandom_range(99) >= 10;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_item(input logic [DATA_W-1:0] slice, input logic [DATA_W-1:0] filter);
      slice_items.push_back('{slice_word: slice, filter_word: filter});
      items_left++;
   endtask

   // wait until every item is taken and every match word is back
   task automatic settle();
      while (items_left != 0 || match_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_LITERAL:   lit_code = data[LITERAL_W-1:0];
         CSR_KIND:      kind_sel = data[KIND_W-1:0];
         CSR_CODE_BITS: code_len_reg = data[CODE_BITS_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // One segment of lanes mostly near the literal, MSB first; take < len cuts it short
   task automatic queue_segment(input int unsigned take, input logic [DATA_W-1:0] filter);
      logic [LITERAL_W-1:0] lane_codes [DATA_W];
      logic [DATA_W-1:0] slice;
      int unsigned len;
      len = seg_slices();
      for (int i = 0; i < DATA_W; i++) begin
         case ($urandom_range(3))
            0: lane_codes[i] = lit_code;
            1: lane_codes[i] = lit_code + 1'b1;
            2: lane_codes[i] = lit_code - 1'b1;
            default: lane_codes[i] = $urandom;
         endcase
      end
      for (int j = 0; j < take; j++) begin
         for (int i = 0; i < DATA_W; i++) slice[i] = lane_codes[i][len - 1 - j];
         // filter only matters on the first slice
         push_item(slice, (j == 0) ? filter : rand_word());
      end
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] junk;
      logic [CODE_BITS_W-1:0] len_code;
      logic [DATA_W-1:0] filter;
      int unsigned pushed;
      int unsigned take;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: 1-bit codes, literal zero, equal
      push_item('0, ALL_LANES);
      push_item(ALL_LANES, ALL_LANES);
      push_item(rand_word(), rand_word());
      settle();

      // all eight kind codes (two unused) over lanes holding all four 2-bit codes
      write_reg(CSR_CODE_BITS, 32'hFFFF_FFC2);
      write_reg(CSR_LITERAL, 32'hFFFF_FFFD);
      foreach (KIND_LIST[k]) begin
         junk = $urandom;
         write_reg(CSR_KIND, {junk[CSR_DATA_W-1:KIND_W], KIND_LIST[k]});
         push_item(MOD4_HIGH, (k % 2 == 0) ? ALL_LANES : rand_word());
         push_item(MOD4_LOW, rand_word());
         settle();
      end

      // zero code length acts as one bit; unused register index is ignored
      write_reg(CSR_CODE_BITS, 32'hFFFF_FFC0);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      push_item(rand_word(), ALL_LANES);
      settle();

      // code length shortened mid-segment ends the segment on the next slice
      write_reg(CSR_KIND, {29'd0, KIND_GE});
      write_reg(CSR_CODE_BITS, 32'd8);
      push_item(rand_word(), rand_word());
      push_item(rand_word(), rand_word());
      push_item(rand_word(), rand_word());
      settle();
      write_reg(CSR_CODE_BITS, 32'd2);
      push_item(rand_word(), rand_word());
      settle();

      // random phases, each with its own configuration
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         steady = (phase == 5);
         junk = $urandom;
         case ($urandom_range(9))
            8: len_code = '0;
            7: len_code = CODE_BITS_W'(DEF_MAX_CODE_BITS);
            6: len_code = CODE_BITS_W'($urandom_range(DEF_MAX_CODE_BITS + 1, 63));
            5: len_code = CODE_BITS_W'($urandom_range(9, DEF_MAX_CODE_BITS - 1));
            default: len_code = CODE_BITS_W'($urandom_range(1, 8));
         endcase
         if (phase == 1) len_code = CODE_BITS_W'(DEF_MAX_CODE_BITS);
         if (phase == 2) len_code = {CODE_BITS_W{1'b1}};
         write_reg(CSR_CODE_BITS, {junk[CSR_DATA_W-1:CODE_BITS_W], len_code});
         junk = $urandom;
         write_reg(CSR_KIND, {junk[CSR_DATA_W-1:KIND_W], KIND_LIST[3'($urandom_range(7))]});
         case (phase)
            1: write_reg(CSR_LITERAL, 32'hFFFF_FFFF);
            2: write_reg(CSR_LITERAL, 32'h0000_0000);
            default: write_reg(CSR_LITERAL, $urandom);
         endcase
         if ($urandom_range(3) == 0) write_reg(CSR_UNUSED, $urandom);

         pushed = 0;
         while (pushed < PHASE_ITEMS) begin
            case ($urandom_range(9))
               0: filter = '0;
               1, 2: filter = ALL_LANES;
               default: filter = rand_word();
            endcase
            // mostly whole segments, now and then a cut-short one
            take = seg_slices();
            if ($urandom_range(9) == 0) take = $urandom_range(1, seg_slices());
            queue_segment(take, filter);
            pushed += take;
            // hold the sender back until every match word is in
            if (phase == 3 && pushed >= PHASE_ITEMS / 2 && pushed - take < PHASE_ITEMS / 2)
               settle();
         end
         settle();
      end
      steady = 1'b0;

      settle();
      if (!failed && match_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/bsps_pkg.sv
rtl/bsps_csr.sv
rtl/bsps_mask_unit.sv
rtl/bit_sliced_predicate_scan.sv
bench/bit_sliced_predicate_scan_tb.sv
